[rtl/trc_pkg.sv]
// Shared types and constants for the terrain radiometric compensation block.
package trc_pkg;

    typedef enum logic [1:0] {
        OUT_PASS  = 2'd0,
        OUT_SCALE = 2'd1,
        OUT_ZERO  = 2'd2
    } outcome_t;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_HEIGHT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SIZE = 8'd1;

    localparam int H_W     = 24;
    localparam int D_W     = H_W + 1;
    localparam int ANG_W   = 16;
    localparam int PS_W    = 16;
    localparam int PIX_W   = 32;
    localparam int IN_W    = 3 * H_W + 2 * ANG_W + PIX_W;
    localparam int AS_W    = D_W + ANG_W;
    localparam int PC_W    = PS_W + 1 + ANG_W;
    localparam int N_W     = 40;
    localparam int SQ_W    = 50;
    localparam int M_W     = 5;
    localparam int M_MAX   = 30;
    localparam int NM_W    = N_W + M_MAX;
    localparam int ROM_W   = 17;
    localparam int FRAC_SH = 15;
    localparam int PIX_SH  = 16;

    // square root: one result bit per stage
    localparam int SQRT_LAT = 31;
    localparam int X_W      = 2 * SQRT_LAT;
    localparam int ROOT_W   = SQRT_LAT;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        outcome_t         kind;
    } carry_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        outcome_t         kind;
        logic [NM_W-1:0]  nm;
    } side_t;

endpackage

[rtl/terrain_radiometric_compensation.sv]
// Top level of the terrain radiometric compensation pipeline.
//
// Accepts one pixel per clock and returns one result per pixel, in order.
// It is built from five front-end stages (slopes, products, sums, two
// normalize steps), 31 square-root stages at one root bit each, one stage
// for the scaled numerator, log2(TABLE_ENTRIES)+1 stages of restoring
// division (a saturation check, then one quotient bit each), one registered
// ROM read and the output register with the final 32x17 multiply. The whole
// pipeline advances together; it holds only while a result sits in the output
// register and m_tready is low. Configuration writes take effect at once and
// are meant for idle periods.
module terrain_radiometric_compensation
    import trc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 512
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input pixel stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [23:0] dem_here, [47:24] dem_left, [71:48] dem_above,
    // [87:72] sin_incidence, [103:88] cos_incidence, [135:104] pixel_in
    input  logic [IN_W-1:0]       s_tdata,
    // [0] first_column
    input  logic [0:0]            s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [31:0] pixel_out
    output logic [PIX_W-1:0]      m_tdata,
    // [1:0] outcome
    output logic [1:0]            m_tuser,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IW    = $clog2(TABLE_ENTRIES);
    localparam int NUM_W = NM_W + IW;
    localparam int DD_W  = ROOT_W + FRAC_SH;
    localparam logic [IW-1:0] IDX_MAX = IW'(TABLE_ENTRIES - 1);

    typedef logic [ROM_W-1:0] rom_arr_t [TABLE_ENTRIES];

    // gain table 1 - 0.7*c^7 in Q1.16, built at elaboration
    function automatic rom_arr_t build_rom();
        rom_arr_t   r;
        logic [63:0] t;
        logic [63:0] p;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            t = (64'(i) << 30) / 64'(TABLE_ENTRIES - 1);
            p = t;
            for (int k = 0; k < 6; k++) begin
                p = (p * t) >> 30;
            end
            r[i] = ROM_W'(64'd65536 - (64'd7 * p + 64'd81920) / 64'd163840);
        end
        return r;
    endfunction

    localparam rom_arr_t ROM = build_rom();

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [H_W-1:0]  bad_height_reg;
    logic [PS_W-1:0] pixel_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bad_height_reg <= '0;
            pixel_size_reg <= PS_W'(200);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BAD_HEIGHT: bad_height_reg <= cfg_data[H_W-1:0];
                CFG_PIXEL_SIZE: pixel_size_reg <= cfg_data[PS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // global advance: everything moves unless the output is blocked
    // ---------------------------------------------------------------
    logic m_valid_reg;
    logic ce;

    assign ce       = !m_valid_reg || m_tready;
    assign s_tready = ce;

    // input unpack
    logic        [H_W-1:0]   in_here, in_left, in_above;
    logic signed [ANG_W-1:0] in_sin, in_cos;
    logic        [PIX_W-1:0] in_pix;

    assign in_here  = s_tdata[H_W-1:0];
    assign in_left  = s_tdata[2*H_W-1:H_W];
    assign in_above = s_tdata[3*H_W-1:2*H_W];
    assign in_sin   = s_tdata[3*H_W+ANG_W-1:3*H_W];
    assign in_cos   = s_tdata[3*H_W+2*ANG_W-1:3*H_W+ANG_W];
    assign in_pix   = s_tdata[IN_W-1:3*H_W+2*ANG_W];

    // ---------------------------------------------------------------
    // stage 1: slopes, sentinel check, pixel size clamp
    // ---------------------------------------------------------------
    logic signed [D_W-1:0] a_d, b_d;

    assign a_d = D_W'($signed(in_here)) - D_W'($signed(in_left));
    assign b_d = D_W'($signed(in_above)) - D_W'($signed(in_here));

    logic                    v1_reg;
    logic signed [D_W-1:0]   a1_reg;
    logic        [H_W-1:0]   ua1_reg, ub1_reg;
    logic signed [ANG_W-1:0] sin1_reg, cos1_reg;
    logic        [PS_W-1:0]  p1_reg;
    logic        [PIX_W-1:0] pix1_reg;
    logic                    first1_reg, bad1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a1_reg     <= a_d;
            ua1_reg    <= a_d[D_W-1] ? H_W'(-a_d) : a_d[H_W-1:0];
            ub1_reg    <= b_d[D_W-1] ? H_W'(-b_d) : b_d[H_W-1:0];
            sin1_reg   <= in_sin;
            cos1_reg   <= in_cos;
            p1_reg     <= (pixel_size_reg == '0) ? PS_W'(1) : pixel_size_reg;
            pix1_reg   <= in_pix;
            first1_reg <= s_tuser[0];
            bad1_reg   <= (in_here == bad_height_reg) || (in_left == bad_height_reg)
                       || (in_above == bad_height_reg);
        end
    end

    // ---------------------------------------------------------------
    // stage 2: numerator terms and squares
    // ---------------------------------------------------------------
    logic signed [PS_W:0] ps1;
    assign ps1 = $signed({1'b0, p1_reg});

    logic                    v2_reg;
    logic signed [AS_W-1:0]  as2_reg;
    logic signed [PC_W-1:0]  pc2_reg;
    logic        [2*H_W-1:0] ua2_reg, ub2_reg;
    logic        [2*PS_W-1:0] pp2_reg;
    logic        [PIX_W-1:0] pix2_reg;
    logic                    first2_reg, bad2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ce) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            as2_reg    <= AS_W'(a1_reg) * AS_W'(sin1_reg);
            pc2_reg    <= PC_W'(ps1) * PC_W'(cos1_reg);
            ua2_reg    <= (2*H_W)'(ua1_reg) * (2*H_W)'(ua1_reg);
            ub2_reg    <= (2*H_W)'(ub1_reg) * (2*H_W)'(ub1_reg);
            pp2_reg    <= (2*PS_W)'(p1_reg) * (2*PS_W)'(p1_reg);
            pix2_reg   <= pix1_reg;
            first2_reg <= first1_reg;
            bad2_reg   <= bad1_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: numerator, sum of squares, outcome decision
    // ---------------------------------------------------------------
    logic signed [AS_W-1:0] n_sum;
    logic        [SQ_W-1:0] sq_sum;
    outcome_t               kind3_next;

    assign n_sum  = as2_reg + AS_W'(pc2_reg);
    assign sq_sum = SQ_W'(ua2_reg) + SQ_W'(ub2_reg) + SQ_W'(pp2_reg);

    always_comb begin
        if (first2_reg) begin
            kind3_next = OUT_PASS;
        end else if (bad2_reg) begin
            kind3_next = OUT_ZERO;
        end else if (n_sum[AS_W-1] || (n_sum == '0)) begin
            kind3_next = OUT_PASS;     // shadow
        end else begin
            kind3_next = OUT_SCALE;
        end
    end

    logic             v3_reg;
    logic [N_W-1:0]   n3_reg;
    logic [SQ_W-1:0]  sq3_reg;
    carry_t           c3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (ce) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            n3_reg  <= n_sum[N_W-1:0];
            sq3_reg <= sq_sum;
            c3_reg  <= '{pix: pix2_reg, kind: kind3_next};
        end
    end

    // ---------------------------------------------------------------
    // stages 4-5: even left shift into [2^60, 2^62)
    // ---------------------------------------------------------------
    logic [X_W-1:0] x4_next;
    logic [M_W-1:0] m4_next;

    always_comb begin
        x4_next = X_W'(sq3_reg);
        m4_next = '0;
        if (x4_next[X_W-1:X_W-32] == '0) begin
            x4_next = x4_next << 32;
            m4_next = m4_next + M_W'(16);
        end
        if (x4_next[X_W-1:X_W-16] == '0) begin
            x4_next = x4_next << 16;
            m4_next = m4_next + M_W'(8);
        end
    end

    logic           v4_reg;
    logic [X_W-1:0] x4_reg;
    logic [M_W-1:0] m4_reg;
    logic [N_W-1:0] n4_reg;
    carry_t         c4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (ce) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x4_reg <= x4_next;
            m4_reg <= m4_next;
            n4_reg <= n3_reg;
            c4_reg <= c3_reg;
        end
    end

    logic [X_W-1:0] x5_next;
    logic [M_W-1:0] m5_next;

    always_comb begin
        x5_next = x4_reg;
        m5_next = m4_reg;
        if (x5_next[X_W-1:X_W-8] == '0) begin
            x5_next = x5_next << 8;
            m5_next = m5_next + M_W'(4);
        end
        if (x5_next[X_W-1:X_W-4] == '0) begin
            x5_next = x5_next << 4;
            m5_next = m5_next + M_W'(2);
        end
        if (x5_next[X_W-1:X_W-2] == '0) begin
            x5_next = x5_next << 2;
            m5_next = m5_next + M_W'(1);
        end
    end

    logic           v5_reg;
    logic [X_W-1:0] x5_reg;
    logic [M_W-1:0] m5_reg;
    logic [N_W-1:0] n5_reg;
    carry_t         c5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (ce) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x5_reg <= x5_next;
            m5_reg <= m5_next;
            n5_reg <= n4_reg;
            c5_reg <= c4_reg;
        end
    end

    // ---------------------------------------------------------------
    // square root, with a matching side line for the rest of the item
    // ---------------------------------------------------------------
    logic [ROOT_W-1:0] root;

    trc_isqrt u_isqrt (
        .aclk     (aclk),
        .ce       (ce),
        .x_in     (x5_reg),
        .root_out (root)
    );

    logic  sv_reg   [SQRT_LAT];
    side_t side_reg [SQRT_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < SQRT_LAT; j++) begin
                sv_reg[j] <= 1'b0;
            end
        end else if (ce) begin
            sv_reg[0] <= v5_reg;
            for (int j = 1; j < SQRT_LAT; j++) begin
                sv_reg[j] <= sv_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            side_reg[0] <= '{pix: c5_reg.pix, kind: c5_reg.kind,
                             nm: NM_W'(n5_reg) << m5_reg};
            for (int j = 1; j < SQRT_LAT; j++) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // scaled numerator and divisor
    // ---------------------------------------------------------------
    logic              v6_reg;
    logic [NUM_W-1:0]  num6_reg;
    logic [DD_W-1:0]   dd6_reg;
    carry_t            c6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (ce) begin
            v6_reg <= sv_reg[SQRT_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            num6_reg <= NUM_W'(side_reg[SQRT_LAT-1].nm) * NUM_W'(TABLE_ENTRIES - 1);
            dd6_reg  <= {root, {FRAC_SH{1'b0}}};
            c6_reg   <= '{pix: side_reg[SQRT_LAT-1].pix, kind: side_reg[SQRT_LAT-1].kind};
        end
    end

    // ---------------------------------------------------------------
    // restoring division: saturation check, then one quotient bit a stage
    // ---------------------------------------------------------------
    logic             dv_reg  [IW+1];
    logic [NUM_W-1:0] rem_reg [IW+1];
    logic [DD_W-1:0]  dd_reg  [IW+1];
    logic [IW-1:0]    q_reg   [IW+1];
    logic             sat_reg [IW+1];
    carry_t           dc_reg  [IW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= IW; i++) begin
                dv_reg[i] <= 1'b0;
            end
        end else if (ce) begin
            dv_reg[0] <= v6_reg;
            for (int i = 1; i <= IW; i++) begin
                dv_reg[i] <= dv_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0] <= num6_reg;
            dd_reg[0]  <= dd6_reg;
            q_reg[0]   <= '0;
            sat_reg[0] <= num6_reg >= (NUM_W'(dd6_reg) << IW);
            dc_reg[0]  <= c6_reg;
            for (int i = 1; i <= IW; i++) begin
                dd_reg[i]  <= dd_reg[i-1];
                sat_reg[i] <= sat_reg[i-1];
                dc_reg[i]  <= dc_reg[i-1];
                if (rem_reg[i-1] >= (NUM_W'(dd_reg[i-1]) << (IW - i))) begin
                    rem_reg[i] <= rem_reg[i-1] - (NUM_W'(dd_reg[i-1]) << (IW - i));
                    q_reg[i]   <= q_reg[i-1] | (IW'(1) << (IW - i));
                end else begin
                    rem_reg[i] <= rem_reg[i-1];
                    q_reg[i]   <= q_reg[i-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // index clamp and registered gain table read
    // ---------------------------------------------------------------
    logic [IW-1:0] idx;
    assign idx = (sat_reg[IW] || (q_reg[IW] > IDX_MAX)) ? IDX_MAX : q_reg[IW];

    logic             vr_reg;
    logic [ROM_W-1:0] rom_reg;
    carry_t           cr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vr_reg <= 1'b0;
        end else if (ce) begin
            vr_reg <= dv_reg[IW];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rom_reg <= ROM[idx];
            cr_reg  <= dc_reg[IW];
        end
    end

    // ---------------------------------------------------------------
    // output register: apply gain, pass through or zero
    // ---------------------------------------------------------------
    logic [PIX_W+ROM_W-1:0] prod;
    logic [PIX_W-1:0]       pixel_out_reg;
    outcome_t               outcome_reg;

    assign prod = (PIX_W+ROM_W)'(cr_reg.pix) * (PIX_W+ROM_W)'(rom_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= vr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            outcome_reg <= cr_reg.kind;
            case (cr_reg.kind)
                OUT_SCALE: pixel_out_reg <= prod[PIX_W+PIX_SH-1:PIX_SH];
                OUT_ZERO:  pixel_out_reg <= '0;
                default:   pixel_out_reg <= cr_reg.pix;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = pixel_out_reg;
    assign m_tuser  = outcome_reg;

`ifndef ASSERT_OFF
    // normalization must leave the root in [2^30, 2^31) for scaled items
    assert property (@(posedge aclk) disable iff (!aresetn)
        sv_reg[SQRT_LAT-1] && (side_reg[SQRT_LAT-1].kind == OUT_SCALE)
            |-> root[ROOT_W-1])
        else $error("square root out of normalized range");

    // unsaturated division must end with a remainder below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        dv_reg[IW] && !sat_reg[IW] && (dc_reg[IW].kind == OUT_SCALE)
            |-> (rem_reg[IW] < NUM_W'(dd_reg[IW])))
        else $error("division remainder not reduced");

    // a bad-height result carries a zero pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == OUT_ZERO) |-> (m_tdata == '0))
        else $error("bad-height result not zeroed");

    // a stalled output transfer keeps the upstream pipeline frozen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(vr_reg) && $stable(rom_reg))
        else $error("pipeline moved during output stall");
`endif

endmodule

[rtl/trc_isqrt.sv]
// Pipelined integer square root, one root bit per register stage.
module trc_isqrt
    import trc_pkg::*;
(
    input  logic              aclk,
    input  logic              ce,
    input  logic [X_W-1:0]    x_in,
    output logic [ROOT_W-1:0] root_out
);

    logic [X_W-1:0] rem_reg [SQRT_LAT];
    logic [X_W-1:0] res_reg [SQRT_LAT];
    logic [X_W-1:0] rem_cur [SQRT_LAT];
    logic [X_W-1:0] res_cur [SQRT_LAT];
    logic [X_W-1:0] bitv    [SQRT_LAT];
    logic [X_W-1:0] trial   [SQRT_LAT];

    always_comb begin
        for (int j = 0; j < SQRT_LAT; j++) begin
            if (j == 0) begin
                rem_cur[j] = x_in;
                res_cur[j] = '0;
            end else begin
                rem_cur[j] = rem_reg[j-1];
                res_cur[j] = res_reg[j-1];
            end
            bitv[j]  = X_W'(1) << (2 * (SQRT_LAT - 1 - j));
            trial[j] = res_cur[j] + bitv[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int j = 0; j < SQRT_LAT; j++) begin
                if (rem_cur[j] >= trial[j]) begin
                    rem_reg[j] <= rem_cur[j] - trial[j];
                    res_reg[j] <= (res_cur[j] >> 1) + bitv[j];
                end else begin
                    rem_reg[j] <= rem_cur[j];
                    res_reg[j] <= res_cur[j] >> 1;
                end
            end
        end
    end

    assign root_out = res_reg[SQRT_LAT-1][ROOT_W-1:0];

endmodule

[tb/terrain_radiometric_compensation_test.sv]
// Self-checking testbench for the terrain radiometric compensation pipeline.
`timescale 1ns / 1ps

module terrain_radiometric_compensation_test;
    import trc_pkg::*;

    localparam int ENTRIES   = 512;
    localparam int LATENCY   = 49;
    localparam int N_RANDOM  = 1550;
    localparam int CYCLE_CAP = 400000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [PIX_W-1:0]      m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    terrain_radiometric_compensation #(.TABLE_ENTRIES(ENTRIES)) dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        outcome_t         kind;
    } pixel_result_t;

    int error_count = 0;

    task automatic report(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // ---- predictor ----
    logic signed [23:0] bad_height_q = '0;
    logic [15:0]        pixel_size_q = 16'd200;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res, bit_w;
        res = '0;
        bit_w = 64'd1 << 62;
        while (bit_w > x) bit_w >>= 2;
        while (bit_w != 0) begin
            if (x >= res + bit_w) begin
                x -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] gain_entry(input logic [63:0] idx);
        logic [63:0] t, p;
        t = (idx << 30) / 64'(ENTRIES - 1);
        p = t;
        for (int k = 0; k < 6; k++) p = (p * t) >> 30;
        return 64'd65536 - (64'd7 * p + 64'd81920) / 64'd163840;
    endfunction

    function automatic pixel_result_t compensate(input logic [IN_W-1:0] d, input logic fc);
        pixel_result_t      r;
        logic signed [23:0] h, l, u;
        logic signed [15:0] s, c;
        logic [31:0]        pix;
        longint             a, b, p, n;
        logic [63:0]        ua, ub, sq, root, num, idx, prod;
        int                 m;
        h = d[23:0]; l = d[47:24]; u = d[71:48];
        s = d[87:72]; c = d[103:88]; pix = d[135:104];
        r.pix = pix;
        r.kind = OUT_PASS;
        if (fc) return r;
        if (h == bad_height_q || l == bad_height_q || u == bad_height_q) begin
            r.pix = '0;
            r.kind = OUT_ZERO;
            return r;
        end
        p = (pixel_size_q == 0) ? 64'sd1 : longint'(pixel_size_q);
        a = longint'(h) - longint'(l);
        b = longint'(u) - longint'(h);
        n = a * longint'(s) + p * longint'(c);
        if (n <= 0) return r;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        sq = ua * ua + ub * ub + p * p;
        m = 0;
        while (sq < (64'd1 << 60)) begin
            sq <<= 2;
            m++;
        end
        root = int_sqrt(sq);
        num = 64'(ENTRIES - 1) * (64'(n) << m);
        idx = num / (root << 15);
        if (idx > 64'(ENTRIES - 1)) idx = 64'(ENTRIES - 1);
        prod = 64'(pix) * gain_entry(idx);
        r.pix = prod[47:16];
        r.kind = OUT_SCALE;
        return r;
    endfunction

    // ---- scoreboard ----
    class pixel_scoreboard;
        pixel_result_t pending[$];

        function void note_input(pixel_result_t e);
            pending.push_back(e);
        endfunction

        task check_result(logic [31:0] pix, logic [1:0] kind);
            pixel_result_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h/%0d", pix, kind));
                return;
            end
            e = pending.pop_front();
            if (pix !== e.pix)
                report($sformatf("pixel_out %h, want %h", pix, e.pix));
            if (kind !== e.kind)
                report($sformatf("outcome %0d, want %0d", kind, e.kind));
        endtask
    endclass

    pixel_scoreboard sb = new();

    // monitors: sample on the edge, drivers update with nonblocking assignments
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_input(compensate(s_tdata, s_tuser[0]));
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // ---- receiver ----
    bit rx_idle_on = 1'b1;
    bit rx_hold = 1'b0;
    always @(posedge aclk) begin
        if (rx_hold) begin
            m_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 11) - 1) @(posedge aclk);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // long hold-off so the pipeline backs up into s_tready
    bit hold_request = 1'b0;
    initial begin
        wait (hold_request);
        @(posedge aclk);
        rx_hold = 1'b1;
        repeat (300) @(posedge aclk);
        rx_hold = 1'b0;
    end

    int cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---- driver tasks ----
    bit tx_idle_on = 1'b1;

    task automatic send_pixel(input logic [IN_W-1:0] d, input logic fc);
        if (tx_idle_on && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= fc;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_BAD_HEIGHT) bad_height_q = v[23:0];
        else if (idx == CFG_PIXEL_SIZE) pixel_size_q = v[15:0];
    endtask

    // quiet the input and let the pipeline empty before a register write
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [IN_W-1:0] pack_pixel(logic [23:0] h, logic [23:0] l,
            logic [23:0] u, logic [15:0] s, logic [15:0] c, logic [31:0] pix);
        return {pix, c, s, u, l, h};
    endfunction

    // mostly realistic terrain around a base height, with some full-range noise
    function automatic logic [IN_W-1:0] random_pixel();
        logic [23:0] base, h, l, u;
        logic [15:0] s, c;
        base = 24'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            h = 24'($urandom); l = 24'($urandom); u = 24'($urandom);
        end else begin
            h = 24'(base + $urandom_range(0, 400) - 200);
            l = 24'(base + $urandom_range(0, 400) - 200);
            u = 24'(base + $urandom_range(0, 400) - 200);
        end
        if ($urandom_range(0, 4) == 0) begin
            s = 16'($urandom); c = 16'($urandom);
        end else begin
            s = 16'($urandom_range(0, 32767));
            c = 16'($urandom_range(0, 32767));
        end
        if ($urandom_range(0, 19) == 0) l = bad_height_q;
        return pack_pixel(h, l, u, s, c, $urandom);
    endfunction

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings
        send_pixel(pack_pixel(24'd0, 24'd0, 24'd0, 16'h7fff, 16'h7fff, 32'hffff_ffff), 1'b1);
        send_pixel(pack_pixel(24'd5, 24'd0, 24'd9, 16'h4000, 16'h6000, 32'h1234), 1'b0);
        send_pixel(pack_pixel(24'd10, 24'd3, 24'd20, 16'h4000, 16'h6000, 32'hffff_ffff), 1'b0);
        send_pixel(pack_pixel(24'd10, 24'd30, 24'd20, 16'h7fff, 16'h8000, 32'h5555), 1'b0);
        send_pixel(pack_pixel(24'd1, 24'd1, 24'd1, 16'h0000, 16'h7fff, 32'hffff_ffff), 1'b0);
        send_pixel(pack_pixel(24'h7fffff, 24'h800000, 24'h800000, 16'h7fff, 16'h7fff,
                              32'h8000_0000), 1'b0);
        send_pixel(pack_pixel(24'h800000, 24'h7fffff, 24'h7fffff, 16'h8000, 16'h8000,
                              32'h0001_0000), 1'b0);
        send_pixel(pack_pixel(24'd100, 24'd50, 24'd150, 16'h8000, 16'h7fff,
                              32'hffff_ffff), 1'b0);
        drain();
        write_reg(CFG_PIXEL_SIZE, 32'd0);
        write_reg(CFG_BAD_HEIGHT, 32'h00800000);
        send_pixel(pack_pixel(24'd2, 24'd1, 24'd3, 16'h7fff, 16'h7fff, 32'hffff_ffff), 1'b0);
        send_pixel(pack_pixel(24'h800000, 24'd1, 24'd3, 16'h7fff, 16'h7fff, 32'h77), 1'b0);
        send_pixel(pack_pixel(24'h800000, 24'd1, 24'd3, 16'h7fff, 16'h7fff, 32'h77), 1'b1);
        send_pixel(pack_pixel(24'd0, 24'd0, 24'd0, 16'h7fff, 16'h7fff, 32'hffff_ffff), 1'b0);
        drain();
        write_reg(CFG_PIXEL_SIZE, 32'd65535);
        write_reg(CFG_BAD_HEIGHT, 32'h007fffff);
        send_pixel(pack_pixel(24'd7, 24'd2, 24'h7fffff, 16'h7fff, 16'h7fff, 32'hffff), 1'b0);
        send_pixel(pack_pixel(24'h800000, 24'h7ffffe, 24'd0, 16'h7fff, 16'h0001,
                              32'hffff_ffff), 1'b0);
        send_pixel(pack_pixel(24'd0, 24'd0, 24'd0, 16'h7fff, 16'h7fff, 32'hffff_ffff), 1'b0);

        // random phases, several register settings
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(CFG_PIXEL_SIZE, 32'd1);
                    write_reg(CFG_BAD_HEIGHT, 32'hffffffff);
                end
                1: begin
                    write_reg(CFG_PIXEL_SIZE, 32'd200);
                    write_reg(CFG_BAD_HEIGHT, $urandom);
                end
                2: write_reg(CFG_PIXEL_SIZE, $urandom_range(1, 65535));
                3: write_reg(CFG_PIXEL_SIZE, 32'd16);
                default: begin
                    write_reg(CFG_PIXEL_SIZE, $urandom_range(1, 2000));
                    tx_idle_on = 1'b0;
                    rx_idle_on = 1'b0;
                end
            endcase
            if (ph == 1) hold_request = 1'b1;
            for (int i = 0; i < N_RANDOM / 5; i++)
                send_pixel(random_pixel(), $urandom_range(0, 15) == 0);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
